FILE: rtl/core/lrupr_pkg.sv
`default_nettype none

package lrupr_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_BITS  = 16;

  localparam int PAGE_W    = 16;
  localparam int IDX_OUT_W = 4;
  localparam int FAULT_W   = 16;
  localparam int CFG_W     = 5;

  localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int LEAVES = 1 << IDX_W;
  localparam int AGE_W  = IDX_W;
  localparam int FILL_W = $clog2(MAX_FRAMES + 1);

  typedef logic [PAGE_W-1:0]    page_t;
  typedef logic [PAGE_BITS-1:0] tag_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [AGE_W-1:0]     age_t;
  typedef logic [FILL_W-1:0]    fill_t;
  typedef logic [FAULT_W-1:0]   fault_t;
  typedef logic [CFG_W-1:0]     cfg_t;

  localparam cfg_t   FRAMES_RESET = CFG_W'(16);
  localparam age_t   AGE_MAX      = AGE_W'(MAX_FRAMES - 1);
  localparam fill_t  FILL_MAX     = FILL_W'(MAX_FRAMES);
  localparam fault_t FAULT_MAX    = '1;

  typedef struct packed {
    page_t page;
    logic  last_ref;
  } item_t;

  typedef struct packed {
    logic                 hit;
    logic [IDX_OUT_W-1:0] frame_index;
    logic                 evicted_valid;
    page_t                evicted_page;
    fault_t               fault_count;
  } result_t;

  typedef struct packed {
    logic [MAX_FRAMES-1:0] valid;
    fill_t                 filled;
  } status_t;

  function automatic tag_t page_to_tag(input page_t p);
    tag_t t;
    t = '0;
    for (int b = 0; b < PAGE_BITS; b++) begin
      if (b < PAGE_W) begin
        t[b] = p[b];
      end
    end
    return t;
  endfunction

  function automatic page_t tag_to_page(input tag_t t);
    page_t p;
    p = '0;
    for (int b = 0; b < PAGE_W; b++) begin
      if (b < PAGE_BITS) begin
        p[b] = t[b];
      end
    end
    return p;
  endfunction

  function automatic logic [IDX_OUT_W-1:0] idx_to_out(input idx_t i);
    logic [IDX_OUT_W-1:0] o;
    o = '0;
    for (int b = 0; b < IDX_OUT_W; b++) begin
      if (b < IDX_W) begin
        o[b] = i[b];
      end
    end
    return o;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lrupr_req_if.sv
`default_nettype none

interface lrupr_req_if;
  logic                valid;
  logic                ready;
  lrupr_pkg::page_t    page;
  logic                last_ref;

  modport source (output valid, output page, output last_ref, input ready);
  modport sink (input valid, input page, input last_ref, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lrupr_rsp_if.sv
`default_nettype none

interface lrupr_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic [lrupr_pkg::IDX_OUT_W-1:0]     frame_index;
  logic                                evicted_valid;
  lrupr_pkg::page_t                    evicted_page;
  lrupr_pkg::fault_t                   fault_count;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output fault_count, input ready);
  modport sink (input valid, input hit, input frame_index, input evicted_valid,
                input evicted_page, input fault_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lrupr_victim_sel.sv
`default_nettype none

module lrupr_victim_sel (
  input  lrupr_pkg::age_t                   ages_i [lrupr_pkg::MAX_FRAMES],
  input  logic [lrupr_pkg::MAX_FRAMES-1:0]  active_i,
  output lrupr_pkg::idx_t                   victim_o
);

  localparam int LVLS = lrupr_pkg::IDX_W;
  localparam int NL   = lrupr_pkg::LEAVES;

  logic            cand_n [LVLS+1][NL];
  lrupr_pkg::age_t age_n  [LVLS+1][NL];
  lrupr_pkg::idx_t idx_n  [LVLS+1][NL];

  // leaves: oldest active frame, lowest index on a tie
  for (genvar i = 0; i < NL; i++) begin : g_leaf
    if (i < lrupr_pkg::MAX_FRAMES) begin : g_used
      assign cand_n[0][i] = active_i[i];
      assign age_n[0][i]  = ages_i[i];
      assign idx_n[0][i]  = lrupr_pkg::IDX_W'(i);
    end else begin : g_pad
      assign cand_n[0][i] = 1'b0;
      assign age_n[0][i]  = '0;
      assign idx_n[0][i]  = '0;
    end
  end

  for (genvar l = 1; l <= LVLS; l++) begin : g_lvl
    for (genvar i = 0; i < NL; i++) begin : g_node
      if (i < (NL >> l)) begin : g_cmp
        logic pick_r;
        assign pick_r = cand_n[l-1][2*i+1] &&
                        (!cand_n[l-1][2*i] || (age_n[l-1][2*i+1] > age_n[l-1][2*i]));
        assign cand_n[l][i] = cand_n[l-1][2*i] || cand_n[l-1][2*i+1];
        assign age_n[l][i]  = pick_r ? age_n[l-1][2*i+1] : age_n[l-1][2*i];
        assign idx_n[l][i]  = pick_r ? idx_n[l-1][2*i+1] : idx_n[l-1][2*i];
      end else begin : g_none
        assign cand_n[l][i] = 1'b0;
        assign age_n[l][i]  = '0;
        assign idx_n[l][i]  = '0;
      end
    end
  end

  assign victim_o = idx_n[LVLS][0];

endmodule

`default_nettype wire

FILE: rtl/core/lrupr_frames.sv
`default_nettype none

module lrupr_frames (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lrupr_pkg::cfg_t     frames_in_use_i,
  input  logic                fire_i,
  input  lrupr_pkg::item_t    item_i,
  output lrupr_pkg::result_t  result_o,
  output lrupr_pkg::status_t  status_o
);

  localparam int NF = lrupr_pkg::MAX_FRAMES;

  lrupr_pkg::tag_t   page_q [NF];
  logic [NF-1:0]     valid_q, valid_d;
  lrupr_pkg::age_t   age_q [NF];
  lrupr_pkg::age_t   age_d [NF];
  lrupr_pkg::fill_t  filled_q, filled_d;
  lrupr_pkg::fault_t faults_q, faults_d, fault_cnt;

  lrupr_pkg::tag_t   tag;
  logic [NF-1:0]     active, match, empty;
  logic              hit, empty_found, evict;
  lrupr_pkg::idx_t   hit_idx, empty_idx, victim_idx, slot;
  lrupr_pkg::age_t   hit_age;

  assign tag = lrupr_pkg::page_to_tag(item_i.page);

  for (genvar k = 0; k < NF; k++) begin : g_cmp
    assign active[k] = (k == 0) || (32'(frames_in_use_i) > k);
    assign match[k]  = active[k] && valid_q[k] && (page_q[k] == tag);
    assign empty[k]  = active[k] && !valid_q[k];
  end

  assign hit         = |match;
  assign empty_found = |empty;
  assign evict       = !hit && !empty_found;

  always_comb begin
    hit_idx   = '0;
    empty_idx = '0;
    for (int k = NF - 1; k >= 0; k--) begin
      if (match[k]) begin
        hit_idx = lrupr_pkg::IDX_W'(k);
      end
      if (empty[k]) begin
        empty_idx = lrupr_pkg::IDX_W'(k);
      end
    end
  end

  lrupr_victim_sel u_victim (
    .ages_i   (age_q),
    .active_i (active),
    .victim_o (victim_idx)
  );

  always_comb begin
    priority if (hit) begin
      slot = hit_idx;
    end else if (empty_found) begin
      slot = empty_idx;
    end else begin
      slot = victim_idx;
    end
  end

  assign hit_age   = age_q[hit_idx];
  assign fault_cnt = (!hit && (faults_q != lrupr_pkg::FAULT_MAX)) ?
                     faults_q + lrupr_pkg::fault_t'(1) : faults_q;

  // recency update, or a clear at the end of a string
  always_comb begin
    valid_d  = valid_q;
    filled_d = filled_q;
    faults_d = faults_q;
    for (int k = 0; k < NF; k++) begin
      age_d[k] = age_q[k];
    end
    if (fire_i) begin
      if (item_i.last_ref) begin
        valid_d  = '0;
        filled_d = '0;
        faults_d = '0;
        for (int k = 0; k < NF; k++) begin
          age_d[k] = '0;
        end
      end else begin
        faults_d = fault_cnt;
        if (!hit && empty_found && (filled_q != lrupr_pkg::FILL_MAX)) begin
          filled_d = filled_q + lrupr_pkg::fill_t'(1);
        end
        for (int k = 0; k < NF; k++) begin
          if (lrupr_pkg::IDX_W'(k) == slot) begin
            valid_d[k] = 1'b1;
            age_d[k]   = '0;
          end else if (valid_q[k] && (age_q[k] != lrupr_pkg::AGE_MAX) &&
                       (!hit || (age_q[k] < hit_age))) begin
            age_d[k] = age_q[k] + lrupr_pkg::age_t'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      filled_q <= '0;
      faults_q <= '0;
      for (int k = 0; k < NF; k++) begin
        age_q[k] <= '0;
      end
    end else begin
      valid_q  <= valid_d;
      filled_q <= filled_d;
      faults_q <= faults_d;
      for (int k = 0; k < NF; k++) begin
        age_q[k] <= age_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NF; k++) begin
      if (fire_i && !hit && (lrupr_pkg::IDX_W'(k) == slot)) begin
        page_q[k] <= tag;
      end
    end
  end

  always_comb begin
    result_o.hit           = hit;
    result_o.frame_index   = lrupr_pkg::idx_to_out(slot);
    result_o.evicted_valid = evict;
    result_o.evicted_page  = evict ? lrupr_pkg::tag_to_page(page_q[victim_idx]) : '0;
    result_o.fault_count   = fault_cnt;
  end

  assign status_o.valid  = valid_q;
  assign status_o.filled = filled_q;

endmodule

`default_nettype wire

FILE: rtl/core/lru_page_replacement_top.sv
// lru page replacement: one page reference in, one result beat out.
// req: sink channel with valid/ready carrying page and last_ref.
// rsp: source channel with valid/ready carrying hit, frame_index,
//   evicted_valid, evicted_page and the running saturating fault_count.
// cfg: cfg_we_i/cfg_wdata_i write frames_in_use (reset 16); write only when idle.
// a request beat lands in an input register; once the output register can
// advance, the frame tags are compared in parallel, the victim is picked by
// an age-rank tree, the frame state updates and the result lands in the
// output register.
// throughput: one reference per cycle while rsp does not stall, set by the
//   tag compare and age update against the frame registers.
// a result with last_ref set is followed by all frames, ages and the fault
//   count returning to empty; frames_in_use keeps its value.
// reset clears all frames and counters at once, no clearing pass.
// when rsp stalls the result holds and the input register takes one more
//   beat; after that req.ready drops until the result is taken.
`default_nettype none

module lru_page_replacement_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  lrupr_pkg::cfg_t      cfg_wdata_i,
  lrupr_req_if.sink            req_i,
  lrupr_rsp_if.source          rsp_o
);

  lrupr_pkg::cfg_t     frames_in_use_q;
  logic                in_valid_q;
  lrupr_pkg::item_t    in_item_q;
  logic                out_valid_q;
  lrupr_pkg::result_t  out_q;
  lrupr_pkg::result_t  result;
  lrupr_pkg::status_t  status;
  logic                advance, fire, take;

  assign advance     = !out_valid_q || rsp_o.ready;
  assign fire        = in_valid_q && advance;
  assign req_i.ready = !in_valid_q || advance;
  assign take        = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= lrupr_pkg::FRAMES_RESET;
    end else if (cfg_we_i) begin
      frames_in_use_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_item_q.page     <= req_i.page;
      in_item_q.last_ref <= req_i.last_ref;
    end
    if (fire) begin
      out_q <= result;
    end
  end

  lrupr_frames u_frames (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frames_in_use_i (frames_in_use_q),
    .fire_i          (fire),
    .item_i          (in_item_q),
    .result_o        (result),
    .status_o        (status)
  );

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.hit           = out_q.hit;
  assign rsp_o.frame_index   = out_q.frame_index;
  assign rsp_o.evicted_valid = out_q.evicted_valid;
  assign rsp_o.evicted_page  = out_q.evicted_page;
  assign rsp_o.fault_count   = out_q.fault_count;

`ifndef NO_ASSERTIONS
  // frames only fill from empty, so the fill count tracks the valid frames
  a_fill_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(status.valid) == 32'(status.filled))
    else $error("fill count differs from valid frames");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.hit && out_q.evicted_valid))
    else $error("hit beat reports an eviction");

  a_evict_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.evicted_valid) |-> (out_q.evicted_page == '0))
    else $error("evicted page set without eviction");

  a_fault_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.hit) |-> (out_q.fault_count != '0))
    else $error("fault beat with zero fault count");

  a_fire_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed reference lost");
`endif

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lrupr_pkg::*;

  localparam int unsigned RANDOM_REFS = 1750;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  class lru_frame_tracker;
    page_t       frame_page [MAX_FRAMES];
    bit          frame_valid [MAX_FRAMES];
    int unsigned frame_age [MAX_FRAMES];
    int unsigned filled;
    int unsigned faults;
    cfg_t        frames_in_use;
    result_t     pending_outcomes[$];
    int unsigned mismatches;

    function new();
      clear_frames();
      frames_in_use = FRAMES_RESET;
      mismatches = 0;
    endfunction

    function void clear_frames();
      for (int k = 0; k < MAX_FRAMES; k++) begin
        frame_page[k] = '0;
        frame_valid[k] = 1'b0;
        frame_age[k] = 0;
      end
      filled = 0;
      faults = 0;
    endfunction

    function void set_frames(input cfg_t v);
      frames_in_use = v;
    endfunction

    function int unsigned pending();
      return pending_outcomes.size();
    endfunction

    function int unsigned active_frames();
      if (frames_in_use == 0) return 1;
      if (frames_in_use > MAX_FRAMES) return MAX_FRAMES;
      return frames_in_use;
    endfunction

    // valid frames younger than the limit grow one step older
    function void age_up_to(input int unsigned limit);
      for (int k = 0; k < MAX_FRAMES; k++) begin
        if (frame_valid[k] && frame_age[k] < limit && frame_age[k] < MAX_FRAMES - 1) begin
          frame_age[k]++;
        end
      end
    endfunction

    function void note_ref(input page_t pg, input logic last);
      result_t     r;
      int unsigned n;
      int unsigned slot;
      int unsigned oldest;
      bit          found;
      r = '0;
      n = active_frames();
      slot = 0;
      found = 1'b0;
      for (int k = 0; k < n; k++) begin
        if (!found && frame_valid[k] && frame_page[k] == pg) begin
          found = 1'b1;
          slot = k;
        end
      end
      if (found) begin
        r.hit = 1'b1;
        age_up_to(frame_age[slot]);
        frame_age[slot] = 0;
      end else begin
        if (faults < FAULT_MAX) faults++;
        for (int k = 0; k < n; k++) begin
          if (!found && !frame_valid[k]) begin
            found = 1'b1;
            slot = k;
          end
        end
        if (found) begin
          if (filled < MAX_FRAMES) filled++;
        end else begin
          // oldest active frame goes, lowest index on a tie
          oldest = 0;
          slot = 0;
          for (int k = 0; k < n; k++) begin
            if (frame_age[k] > oldest) begin
              oldest = frame_age[k];
              slot = k;
            end
          end
          r.evicted_valid = 1'b1;
          r.evicted_page = frame_page[slot];
          frame_valid[slot] = 1'b0;
        end
        age_up_to(MAX_FRAMES);
        frame_page[slot] = pg;
        frame_valid[slot] = 1'b1;
        frame_age[slot] = 0;
      end
      r.frame_index = IDX_OUT_W'(slot);
      r.fault_count = FAULT_W'(faults);
      pending_outcomes.push_back(r);
      if (last) clear_frames();
    endfunction

    function void check_result(input result_t got);
      result_t exp;
      bit      bad;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result beat: hit %0d frame %0d ev %0d/%h faults %0d",
                   got.hit, got.frame_index, got.evicted_valid, got.evicted_page,
                   got.fault_count);
        end
      end else begin
        exp = pending_outcomes.pop_front();
        bad = (got.hit !== exp.hit) || (got.frame_index !== exp.frame_index) ||
              (got.evicted_valid !== exp.evicted_valid) ||
              (got.evicted_page !== exp.evicted_page) ||
              (got.fault_count !== exp.fault_count);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected hit %0d frame %0d ev %0d/%h faults %0d",
                     exp.hit, exp.frame_index, exp.evicted_valid, exp.evicted_page,
                     exp.fault_count);
            $display("                 actual   hit %0d frame %0d ev %0d/%h faults %0d",
                     got.hit, got.frame_index, got.evicted_valid, got.evicted_page,
                     got.fault_count);
          end
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_t cfg_wdata;

  lrupr_req_if req_bus ();
  lrupr_rsp_if rsp_bus ();

  lru_page_replacement_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_bus.sink),
    .rsp_o       (rsp_bus.source)
  );

  lru_frame_tracker tracker;
  int unsigned src_idle_pct = 34;
  int unsigned snk_idle_pct = 34;
  int unsigned sink_hold = 0;
  int unsigned random_sent = 0;
  int unsigned cycle_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lru_page_replacement_top verification failed");
      $finish;
    end
  end

  initial begin
    result_t got;
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
        got.hit = rsp_bus.hit;
        got.frame_index = rsp_bus.frame_index;
        got.evicted_valid = rsp_bus.evicted_valid;
        got.evicted_page = rsp_bus.evicted_page;
        got.fault_count = rsp_bus.fault_count;
        tracker.check_result(got);
      end
      if (sink_hold > 0) begin
        rsp_bus.ready <= 1'b0;
        sink_hold--;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic send_ref(input page_t pg, input logic last);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.page <= pg;
    req_bus.last_ref <= last;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    tracker.note_ref(pg, last);
  endtask

  task automatic drain();
    req_bus.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_frames(input cfg_t v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_frames(v);
  endtask

  function automatic cfg_t pick_frames();
    case ($urandom_range(9))
      0: return cfg_t'(0);
      1: return cfg_t'(1);
      2: return cfg_t'(MAX_FRAMES);
      3: return cfg_t'($urandom_range(MAX_FRAMES + 1, 31));
      default: return cfg_t'($urandom_range(1, MAX_FRAMES));
    endcase
  endfunction

  // reference string drawn mostly from a small working set
  task automatic run_string(input int unsigned len, input bit close);
    page_t       pool[$];
    int unsigned pool_size;
    page_t       pg;
    pool_size = $urandom_range(1, tracker.active_frames() + 4);
    repeat (pool_size) pool.push_back(page_t'($urandom));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 85) pg = pool[$urandom_range(pool_size - 1)];
      else pg = page_t'($urandom);
      send_ref(pg, (close && i == len - 1) || $urandom_range(199) == 0);
      random_sent++;
    end
  endtask

  initial begin
    bit    hold_done;
    tracker = new();
    hold_done = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_bus.valid = 1'b0;
    req_bus.page = '0;
    req_bus.last_ref = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset frame count, extreme pages
    send_ref(16'h0000, 1'b0);
    send_ref(16'hffff, 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'hffff, 1'b1);
    drain();
    write_frames(cfg_t'(2));
    send_ref(16'h5a5a, 1'b0);
    send_ref(16'ha5a5, 1'b0);
    send_ref(16'h5a5a, 1'b0);
    send_ref(16'h0001, 1'b0);
    send_ref(16'h8000, 1'b0);
    // frame count shrinks mid-string, zero acts as one
    drain();
    write_frames(cfg_t'(0));
    send_ref(16'h8000, 1'b0);
    send_ref(16'h0001, 1'b0);
    drain();
    write_frames(cfg_t'(31));
    send_ref(16'h0001, 1'b0);
    send_ref(16'h1234, 1'b0);
    send_ref(16'h4321, 1'b1);

    while (random_sent < RANDOM_REFS) begin
      drain();
      write_frames(pick_frames());
      if (random_sent >= 900 && random_sent < 1250) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end else begin
        src_idle_pct = 34;
        snk_idle_pct = 34;
      end
      if (!hold_done && random_sent > 500) begin
        sink_hold = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      repeat ($urandom_range(1, 3)) run_string($urandom_range(1, 60), $urandom_range(3) != 0);
    end

    drain();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("lru_page_replacement_top verification clean");
    end else begin
      $display("lru_page_replacement_top verification failed");
    end
    $finish;
  end

endmodule

FILE: lru_page_replacement_top.f
rtl/core/lrupr_pkg.sv
rtl/core/lrupr_req_if.sv
rtl/core/lrupr_rsp_if.sv
rtl/core/lrupr_victim_sel.sv
rtl/core/lrupr_frames.sv
rtl/core/lru_page_replacement_top.sv
bench/testbench.sv
